[hdl/assert_macros.svh]
// Assertion macros for the list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition implies another at the same clock edge.
`define ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

[hdl/alidl_pkg.sv]
// Types, constants and sizes shared by the positional list cells, groups and top level.
package alidl_pkg;

	localparam int DEPTH   = 1024;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 11;
	localparam int VAL_W   = 32;
	localparam int GROUP   = 32;
	localparam int NGROUP  = DEPTH / GROUP;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int GRP_W   = $clog2(GROUP);
	localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	typedef enum logic [1:0] {
		ACT_GET    = 2'd0,
		ACT_LOCATE = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_UNDERFLOW = 2'd3
	} status_t;

	// Broadcast to every cell for the request in stage one.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic              pick_en;
		logic              loc;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] word;
	} cell_ctl_t;

endpackage

[hdl/alidl_cell.sv]
// One list cell: holds one entry, shifts with its neighbours, flags match and pick.
module alidl_cell (
	input  logic                                clk,
	input  alidl_pkg::cell_ctl_t                ctl,
	input  logic [alidl_pkg::IDX_W-1:0]         cell_index,
	input  logic [alidl_pkg::DATA_W-1:0]        left_word,
	input  logic [alidl_pkg::DATA_W-1:0]        right_word,
	output logic [alidl_pkg::DATA_W-1:0]        word,
	output logic                                hit,
	output logic                                pick
);

	logic [alidl_pkg::DATA_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (cell_index == ctl.idx) begin
				word_q <= ctl.word;
			end else if (cell_index > ctl.idx) begin
				word_q <= left_word;
			end
		end else if (ctl.del) begin
			if (cell_index >= ctl.idx) begin
				word_q <= right_word;
			end
		end
	end

	assign word = word_q;
	assign pick = ctl.pick_en && (cell_index == ctl.idx);
	assign hit  = ctl.loc && (alidl_pkg::CNT_W'(cell_index) < ctl.cnt) && (word_q == ctl.word);

endmodule

[hdl/alidl_group.sv]
// A group of list cells with a registered first-match and read-out reduction.
module alidl_group (
	input  logic                                clk,
	input  logic                                adv,
	input  alidl_pkg::cell_ctl_t                ctl,
	input  logic [alidl_pkg::IDX_W-1:0]         base,
	input  logic [alidl_pkg::DATA_W-1:0]        left_word,
	input  logic [alidl_pkg::DATA_W-1:0]        right_word,
	output logic [alidl_pkg::DATA_W-1:0]        first_word,
	output logic [alidl_pkg::DATA_W-1:0]        last_word,
	output logic                                any_s2,
	output logic [alidl_pkg::GRP_W-1:0]         first_s2,
	output logic [alidl_pkg::DATA_W-1:0]        rd_s2
);

	logic [alidl_pkg::DATA_W-1:0] words [alidl_pkg::GROUP];
	logic [alidl_pkg::GROUP-1:0]  hit;
	logic [alidl_pkg::GROUP-1:0]  pick;
	logic                         any_c;
	logic [alidl_pkg::GRP_W-1:0]  first_c;
	logic [alidl_pkg::DATA_W-1:0] rd_c;

	for (genvar j = 0; j < alidl_pkg::GROUP; j++) begin : g_cell
		logic [alidl_pkg::DATA_W-1:0] lw;
		logic [alidl_pkg::DATA_W-1:0] rw;
		if (j == 0) begin : g_first
			assign lw = left_word;
		end else begin : g_mid_l
			assign lw = words[j-1];
		end
		if (j == alidl_pkg::GROUP - 1) begin : g_last
			assign rw = right_word;
		end else begin : g_mid_r
			assign rw = words[j+1];
		end
		alidl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cell_index (base + alidl_pkg::IDX_W'(j)),
			.left_word  (lw),
			.right_word (rw),
			.word       (words[j]),
			.hit        (hit[j]),
			.pick       (pick[j])
		);
	end

	assign first_word = words[0];
	assign last_word  = words[alidl_pkg::GROUP-1];

	// Lowest matching cell wins.
	always_comb begin
		any_c   = 1'b0;
		first_c = '0;
		rd_c    = '0;
		for (int j = alidl_pkg::GROUP - 1; j >= 0; j--) begin
			if (hit[j]) begin
				any_c   = 1'b1;
				first_c = alidl_pkg::GRP_W'(j);
			end
		end
		for (int j = 0; j < alidl_pkg::GROUP; j++) begin
			rd_c = rd_c | (pick[j] ? words[j] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			any_s2   <= any_c;
			first_s2 <= first_c;
			rd_s2    <= rd_c;
		end
	end

endmodule

[hdl/array_list_insert_delete_locate.sv]
// Positional list of up to 1024 signed words: get, locate, insert and delete by one-based position.
//
// The entries sit in a row of 1024 cells, split into 32 groups of 32. A request is registered
// on acceptance (stage one); in the next cycle every cell compares its own index with the
// position and its entry with the search word, and on a successful insert or delete the cells
// from that position on shift by one place at that same edge, while each group registers its
// first match and the entry picked for get or delete (stage two). The group results are then
// combined into the output register. Requests follow one another back to back: one per cycle
// sustained while the output does not stall, with the row update of each one done before the
// next reaches the cells. A stalled output holds the whole pipeline, and then in_ready is low.
// Entries are not cleared after reset; only positions 1 to list_length are ever read, and all
// of those have been written by an insert. list_length is the count after the request; a
// failed request leaves the list as it was.
`include "assert_macros.svh"

module array_list_insert_delete_locate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          action,
	input  logic [alidl_pkg::POS_W-1:0]         position,
	input  logic signed [alidl_pkg::VAL_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [alidl_pkg::VAL_W-1:0]  read_value,
	output logic [alidl_pkg::POS_W-1:0]         found_position,
	output logic [1:0]                          status,
	output logic [alidl_pkg::POS_W-1:0]         list_length
);

	// Pipeline advance: everything moves unless a result waits on a stalled output.
	logic adv;

	// Stage one: the registered request.
	logic                          v_s1;
	alidl_pkg::action_t            action_s1;
	logic [alidl_pkg::POS_W-1:0]   position_s1;
	logic [alidl_pkg::DATA_W-1:0]  value_s1;

	// Entry count, updated as each request passes stage one.
	logic [alidl_pkg::CNT_W-1:0]   count_q;
	logic [alidl_pkg::CNT_W-1:0]   count_next;

	// Stage one decode.
	alidl_pkg::status_t            status_c;
	alidl_pkg::cell_ctl_t          ctl;
	logic                          ins_c;
	logic                          del_c;
	logic                          pick_c;
	logic                          loc_c;
	logic [alidl_pkg::CMP_W-1:0]   pos_x;
	logic [alidl_pkg::CMP_W-1:0]   cnt_x;

	// Stage two.
	logic                          v_s2;
	alidl_pkg::status_t            status_s2;
	logic [alidl_pkg::CNT_W-1:0]   len_s2;

	// Group row.
	logic [alidl_pkg::DATA_W-1:0]  g_first_word [alidl_pkg::NGROUP];
	logic [alidl_pkg::DATA_W-1:0]  g_last_word  [alidl_pkg::NGROUP];
	logic                          g_any        [alidl_pkg::NGROUP];
	logic [alidl_pkg::GRP_W-1:0]   g_first      [alidl_pkg::NGROUP];
	logic [alidl_pkg::DATA_W-1:0]  g_rd         [alidl_pkg::NGROUP];

	// Final combine.
	logic [alidl_pkg::DATA_W-1:0]  rd_c;
	logic [alidl_pkg::CNT_W-1:0]   found_c;

	// Output register.
	logic                          out_valid_q;
	logic [alidl_pkg::VAL_W-1:0]   read_value_q;
	logic [alidl_pkg::POS_W-1:0]   found_position_q;
	alidl_pkg::status_t            status_q;
	logic [alidl_pkg::POS_W-1:0]   list_length_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Take a new request whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			action_s1   <= alidl_pkg::action_t'(action);
			position_s1 <= position;
			value_s1    <= alidl_pkg::DATA_W'(value);
		end
	end

	// Check the request against the current count. Insert tests for a full list before the
	// position, delete tests for an empty list before the position.
	assign pos_x = alidl_pkg::CMP_W'(position_s1);
	assign cnt_x = alidl_pkg::CMP_W'(count_q);

	always_comb begin
		status_c   = alidl_pkg::ST_OK;
		ins_c      = 1'b0;
		del_c      = 1'b0;
		pick_c     = 1'b0;
		loc_c      = 1'b0;
		count_next = count_q;
		case (action_s1)
			alidl_pkg::ACT_GET: begin
				if (position_s1 == '0 || pos_x > cnt_x) begin
					status_c = alidl_pkg::ST_BAD_POS;
				end else begin
					pick_c = 1'b1;
				end
			end
			alidl_pkg::ACT_LOCATE: begin
				loc_c = 1'b1;
			end
			alidl_pkg::ACT_INSERT: begin
				if (count_q == alidl_pkg::CNT_W'(alidl_pkg::DEPTH)) begin
					status_c = alidl_pkg::ST_OVERFLOW;
				end else if (position_s1 == '0 || pos_x > cnt_x + alidl_pkg::CMP_W'(1)) begin
					status_c = alidl_pkg::ST_BAD_POS;
				end else begin
					ins_c      = 1'b1;
					count_next = count_q + alidl_pkg::CNT_W'(1);
				end
			end
			alidl_pkg::ACT_DELETE: begin
				if (count_q == '0) begin
					status_c = alidl_pkg::ST_UNDERFLOW;
				end else if (position_s1 == '0 || pos_x > cnt_x) begin
					status_c = alidl_pkg::ST_BAD_POS;
				end else begin
					del_c      = 1'b1;
					pick_c     = 1'b1;
					count_next = count_q - alidl_pkg::CNT_W'(1);
				end
			end
			default: begin
				status_c = alidl_pkg::ST_OK;
			end
		endcase
	end

	// Broadcast to the row; shifts fire only on the advancing edge of a valid request.
	assign ctl.ins     = adv && v_s1 && ins_c;
	assign ctl.del     = adv && v_s1 && del_c;
	assign ctl.pick_en = v_s1 && pick_c;
	assign ctl.loc     = v_s1 && loc_c;
	assign ctl.idx     = alidl_pkg::IDX_W'(position_s1 - alidl_pkg::POS_W'(1));
	assign ctl.cnt     = count_q;
	assign ctl.word    = value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s2    <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_c;
			len_s2    <= count_next;
		end
	end

	// The row of groups; neighbouring groups hand their edge entries across.
	for (genvar g = 0; g < alidl_pkg::NGROUP; g++) begin : g_grp
		logic [alidl_pkg::DATA_W-1:0] lw;
		logic [alidl_pkg::DATA_W-1:0] rw;
		if (g == 0) begin : g_head
			assign lw = '0;
		end else begin : g_mid_l
			assign lw = g_last_word[g-1];
		end
		if (g == alidl_pkg::NGROUP - 1) begin : g_tail
			assign rw = '0;
		end else begin : g_mid_r
			assign rw = g_first_word[g+1];
		end
		alidl_group u_group (
			.clk        (clk),
			.adv        (adv),
			.ctl        (ctl),
			.base       (alidl_pkg::IDX_W'(g * alidl_pkg::GROUP)),
			.left_word  (lw),
			.right_word (rw),
			.first_word (g_first_word[g]),
			.last_word  (g_last_word[g]),
			.any_s2     (g_any[g]),
			.first_s2   (g_first[g]),
			.rd_s2      (g_rd[g])
		);
	end

	// Combine the groups: at most one group holds the picked entry; the lowest group with a
	// match gives the found position.
	always_comb begin
		rd_c    = '0;
		found_c = '0;
		for (int g = 0; g < alidl_pkg::NGROUP; g++) begin
			rd_c = rd_c | g_rd[g];
		end
		for (int g = alidl_pkg::NGROUP - 1; g >= 0; g--) begin
			if (g_any[g]) begin
				found_c = alidl_pkg::CNT_W'(g * alidl_pkg::GROUP)
				        + alidl_pkg::CNT_W'(g_first[g]) + alidl_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_value_q     <= alidl_pkg::VAL_W'(rd_c);
			found_position_q <= alidl_pkg::POS_W'(found_c);
			status_q         <= status_s2;
			list_length_q    <= alidl_pkg::POS_W'(len_s2);
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign found_position = found_position_q;
	assign status         = status_q;
	assign list_length    = list_length_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= alidl_pkg::CNT_W'(alidl_pkg::DEPTH), "count above depth")
	`ASSERT_IMPLIES(a_overflow_full, out_valid && status == alidl_pkg::ST_OVERFLOW, list_length == alidl_pkg::POS_W'(alidl_pkg::DEPTH), "overflow on a list that is not full")
	`ASSERT_IMPLIES(a_underflow_empty, out_valid && status == alidl_pkg::ST_UNDERFLOW, list_length == '0, "underflow on a list that is not empty")
	`ASSERT_IMPLIES(a_found_in_range, out_valid && found_position != '0, found_position <= list_length, "found position beyond list end")

endmodule

[test/list_tracker_pkg.sv]
// Shadow copy of the positional list and the queue of results it still owes.
package list_tracker_pkg;

	import alidl_pkg::*;

	typedef struct {
		logic signed [VAL_W-1:0] read_value;
		logic [POS_W-1:0]        found_position;
		logic [1:0]              status;
		logic [POS_W-1:0]        list_length;
	} list_result_t;

	class list_scoreboard;
		logic signed [DATA_W-1:0] entries [DEPTH];
		int                       count;
		int                       errors;
		list_result_t             awaited_results [$];

		function new();
			count  = 0;
			errors = 0;
		endfunction

		// Apply one accepted request to the shadow list and queue the result it owes.
		function void note_request(action_t act, logic [POS_W-1:0] pos,
				logic signed [VAL_W-1:0] val);
			list_result_t r;
			int p;
			p                = int'(pos);
			r.read_value     = '0;
			r.found_position = '0;
			r.status         = ST_OK;
			case (act)
				ACT_GET: begin
					if (p == 0 || p > count)
						r.status = ST_BAD_POS;
					else
						r.read_value = entries[p-1];
				end
				ACT_LOCATE: begin
					for (int k = 0; k < count; k++) begin
						if (entries[k] == val) begin
							r.found_position = POS_W'(k + 1);
							break;
						end
					end
				end
				ACT_INSERT: begin
					if (count >= DEPTH) begin
						r.status = ST_OVERFLOW;
					end else if (p == 0 || p > count + 1) begin
						r.status = ST_BAD_POS;
					end else begin
						for (int k = count; k >= p; k--)
							entries[k] = entries[k-1];
						entries[p-1] = val;
						count++;
					end
				end
				default: begin
					if (count == 0) begin
						r.status = ST_UNDERFLOW;
					end else if (p == 0 || p > count) begin
						r.status = ST_BAD_POS;
					end else begin
						r.read_value = entries[p-1];
						for (int k = p; k < count; k++)
							entries[k-1] = entries[k];
						count--;
					end
				end
			endcase
			r.list_length = POS_W'(count);
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic signed [VAL_W-1:0] rv, logic [POS_W-1:0] fp,
				logic [1:0] st, logic [POS_W-1:0] ll);
			list_result_t e;
			if (awaited_results.size() == 0) begin
				$error("result with none outstanding: read_value %0d status %0d", rv, st);
				errors++;
				return;
			end
			e = awaited_results.pop_front();
			if (rv !== e.read_value) begin
				$error("read_value: expected %0d, actual %0d", e.read_value, rv);
				errors++;
			end
			if (fp !== e.found_position) begin
				$error("found_position: expected %0d, actual %0d", e.found_position, fp);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (ll !== e.list_length) begin
				$error("list_length: expected %0d, actual %0d", e.list_length, ll);
				errors++;
			end
		endfunction
	endclass

endpackage

[test/tb_top.sv]
// Top level of the positional list testbench: clock, reset, drivers, monitors and stimulus.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import alidl_pkg::*;
	import list_tracker_pkg::*;

	// Receiver hold-off long enough to fill the pipeline and stall the input side.
	localparam int LONG_HOLD   = 300;
	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT = 5000;
	// Allow a margin after the last result.
	localparam int SETTLE      = 10;

	localparam logic signed [VAL_W-1:0] VALUE_POOL [8] = '{
		32'sh0000_0000, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
		32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003, 32'sh0000_002A
	};

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    in_valid       = 1'b0;
	logic                    in_ready;
	logic [1:0]              action         = ACT_GET;
	logic [POS_W-1:0]        position       = '0;
	logic signed [VAL_W-1:0] value          = '0;
	logic                    out_valid;
	logic                    out_ready      = 1'b0;
	logic signed [VAL_W-1:0] read_value;
	logic [POS_W-1:0]        found_position;
	logic [1:0]              status;
	logic [POS_W-1:0]        list_length;

	// Idling odds in percent, owned by the stimulus process.
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	// Bump to ask the receiver for one long hold-off.
	int hold_token   = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	list_scoreboard sb = new();

	array_list_insert_delete_locate dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.position       (position),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_value     (read_value),
		.found_position (found_position),
		.status         (status),
		.list_length    (list_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: stall at random, or hold off for a long stretch when asked.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Check every result taken by the receiver against the oldest outstanding one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(read_value, found_position, status, list_length);
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$error("no handshake for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one request after a random idle gap, hold it until taken, then note it.
	task automatic send_request(action_t a, logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= a;
		position <= p;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_request(a, p, v);
	endtask

	// Lower valid and wait until every outstanding result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(int tx_pct, int rx_pct);
		tx_idle_pct  <= tx_pct;
		rx_stall_pct <= rx_pct;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(99) < 50)
			return VALUE_POOL[$urandom_range(7)];
		return $urandom();
	endfunction

	// Mostly well-formed requests on the current list, with some bad positions and noise.
	task automatic random_request(int ins_w, int del_w);
		action_t                 a;
		logic [POS_W-1:0]        p;
		logic signed [VAL_W-1:0] v;
		int roll;
		int cnt;
		int span;
		cnt  = sb.count;
		roll = $urandom_range(99);
		if (roll < ins_w)
			a = ACT_INSERT;
		else if (roll < ins_w + del_w)
			a = ACT_DELETE;
		else if (roll[0])
			a = ACT_GET;
		else
			a = ACT_LOCATE;
		span = (a == ACT_INSERT) ? cnt + 1 : cnt;
		roll = $urandom_range(99);
		if (roll < 80 && span > 0)
			p = POS_W'($urandom_range(span, 1));
		else if (roll < 88)
			p = POS_W'(span + 1);
		else if (roll < 92)
			p = '0;
		else
			p = POS_W'($urandom());
		// Search for a stored entry half the time so that hits are common.
		if (a == ACT_LOCATE && cnt > 0 && $urandom_range(99) < 50)
			v = sb.entries[$urandom_range(cnt - 1)];
		else
			v = pick_value();
		send_request(a, p, v);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, edges of position, ends and middle, duplicates.
		set_idling(0, 0);
		send_request(ACT_GET,    11'd1,    32'sd0);
		send_request(ACT_DELETE, 11'd1,    32'sd0);
		// Underflow takes precedence over a bad position.
		send_request(ACT_DELETE, 11'd0,    32'sd0);
		send_request(ACT_LOCATE, 11'd0,    32'sd0);
		send_request(ACT_INSERT, 11'd0,    32'sd5);
		send_request(ACT_INSERT, 11'd2,    32'sd5);
		send_request(ACT_INSERT, 11'd1,    32'sh7FFF_FFFF);
		send_request(ACT_INSERT, 11'd2,    32'sh8000_0000);
		send_request(ACT_INSERT, 11'd1,    32'shFFFF_FFFF);
		send_request(ACT_INSERT, 11'd2,    32'sd0);
		send_request(ACT_INSERT, 11'd6,    32'sd9);
		send_request(ACT_INSERT, 11'd2047, 32'sd9);
		send_request(ACT_GET,    11'd0,    32'sd0);
		send_request(ACT_GET,    11'd4,    32'sd0);
		send_request(ACT_GET,    11'd5,    32'sd0);
		send_request(ACT_GET,    11'd2047, 32'sd0);
		send_request(ACT_LOCATE, 11'd0,    32'sh8000_0000);
		send_request(ACT_LOCATE, 11'd3,    32'sd12345);
		send_request(ACT_INSERT, 11'd3,    32'shFFFF_FFFF);
		// Locate ignores position and must report the first of two matches.
		send_request(ACT_LOCATE, 11'd2047, 32'shFFFF_FFFF);
		send_request(ACT_DELETE, 11'd0,    32'sd0);
		send_request(ACT_DELETE, 11'd6,    32'sd0);
		send_request(ACT_DELETE, 11'd2047, 32'sd0);
		send_request(ACT_DELETE, 11'd3,    32'sd0);
		send_request(ACT_DELETE, 11'd4,    32'sd0);
		drain_results();

		// Sender mostly idle on a short list.
		set_idling(84, 0);
		repeat (250) random_request(40, 30);
		drain_results();

		// Receiver mostly stalling; open with a long hold-off while requests keep coming.
		set_idling(0, 84);
		hold_token <= hold_token + 1;
		repeat (250) random_request(40, 30);
		drain_results();

		// Both sides idling a little: fill the list to the brim.
		set_idling(12, 12);
		while (sb.count < DEPTH)
			send_request(ACT_INSERT, POS_W'($urandom_range(sb.count + 1, 1)), pick_value());
		// Overflow takes precedence over any position.
		send_request(ACT_INSERT, 11'd0,    32'sd1);
		send_request(ACT_INSERT, 11'd1,    32'sd1);
		send_request(ACT_INSERT, 11'd1025, 32'sd1);
		send_request(ACT_INSERT, 11'd2047, 32'sd1);
		send_request(ACT_GET,    11'd1024, 32'sd0);
		send_request(ACT_GET,    11'd1025, 32'sd0);
		send_request(ACT_LOCATE, 11'd0,    sb.entries[DEPTH-1]);
		send_request(ACT_DELETE, 11'd1025, 32'sd0);
		send_request(ACT_DELETE, 11'd1024, 32'sd0);
		send_request(ACT_INSERT, 11'd1024, 32'sh7FFF_FFFF);
		drain_results();

		// No idling, delete-heavy on a long list.
		set_idling(0, 0);
		repeat (250) random_request(20, 50);
		drain_results();

		// Allow any stray result to surface before the verdict.
		repeat (SETTLE) @(posedge clk);
		if (sb.awaited_results.size() != 0) begin
			$error("%0d results never arrived", sb.awaited_results.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
